[rtl/core/trbc_pkg.sv]
package trbc_pkg;

  localparam int NUM_CH = 30;
  localparam int CH_W = $clog2(NUM_CH);
  localparam int ID_W = 5;
  localparam int LVL_W = 30;
  localparam int SEC_W = 16;
  localparam int CTR_W = 26;
  localparam int TICKS_PER_SECOND = 1000;
  localparam int CMD_W = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_SET = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_code_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic [CH_W-1:0] idx;
    logic report;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic out_busy;
  } dp_stat_t;

endpackage

[rtl/core/trbc_dpath.sv]
module trbc_dpath import trbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LVL_W-1:0]     cfg_data,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [ID_W-1:0]      in_relay_id,
  input  logic                 in_state,
  input  logic [SEC_W-1:0]     in_run_time_s,
  input  logic [SEC_W-1:0]     in_delay_s,
  input  dp_cmd_t              ctl,
  output dp_stat_t             stat,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic                 out_status,
  output logic [LVL_W-1:0]     out_levels,
  output logic                 out_desired,
  output logic                 out_actual,
  output logic [CTR_W-1:0]     out_run_left,
  output logic [CTR_W-1:0]     out_delay_left
);

  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0]  id_q;
  logic             st_q;
  logic [SEC_W-1:0] run_s_q;
  logic [SEC_W-1:0] dly_s_q;

  logic [LVL_W-1:0]  chan_en;
  logic              active_high;
  logic [NUM_CH-1:0] desired;
  logic [NUM_CH-1:0] applied;
  logic [CTR_W-1:0]  run_ctr [NUM_CH];
  logic [CTR_W-1:0]  dly_ctr [NUM_CH];
  logic              status_q;

  logic [CH_W-1:0]  rd_addr;
  logic [CTR_W-1:0] rd_run;
  logic [CTR_W-1:0] rd_dly;
  logic             id_ok;
  logic             id_present;
  logic [CTR_W-1:0] run_ticks;
  logic [CTR_W-1:0] dly_ticks;
  logic [LVL_W-1:0] levels;

  assign rd_addr = ctl.report ? id_q[CH_W-1:0] : ctl.idx;
  assign rd_run = run_ctr[rd_addr];
  assign rd_dly = dly_ctr[rd_addr];
  assign id_ok = (id_q < ID_W'(NUM_CH));
  assign id_present = id_ok && chan_en[id_q[CH_W-1:0]];
  assign run_ticks = CTR_W'(run_s_q) * CTR_W'(TICKS_PER_SECOND);
  assign dly_ticks = CTR_W'(dly_s_q) * CTR_W'(TICKS_PER_SECOND);

  always_comb begin
    for (int i = 0; i < LVL_W; i++) begin
      levels[i] = (i < NUM_CH) ? (applied[i] ^ ~active_high) : 1'b0;
    end
  end

  assign stat.cmd = cmd_q;
  assign stat.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= in_cmd;
      id_q <= in_relay_id;
      st_q <= in_state;
      run_s_q <= in_run_time_s;
      dly_s_q <= in_delay_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_en <= '0;
      active_high <= 1'b1;
      desired <= '0;
      applied <= '0;
      status_q <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        run_ctr[i] <= '0;
        dly_ctr[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNEL_ENABLE: chan_en <= cfg_data;
          CFG_ACTIVE_HIGH:    active_high <= cfg_data[0];
          default: ;
        endcase
      end

      if (ctl.exec) begin
        case (cmd_q)
          CMD_SET: begin
            status_q <= !id_present;
            if (id_present) begin
              desired[id_q[CH_W-1:0]] <= st_q;
              if (dly_s_q == '0) begin
                applied[id_q[CH_W-1:0]] <= st_q;
              end
              run_ctr[id_q[CH_W-1:0]] <= run_ticks;
              dly_ctr[id_q[CH_W-1:0]] <= dly_ticks;
            end
          end
          CMD_CLEAR: begin
            status_q <= 1'b0;
            desired <= '0;
            applied <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
              run_ctr[i] <= '0;
              dly_ctr[i] <= '0;
            end
          end
          default: status_q <= 1'b0;
        endcase
      end

      // one channel per cycle: delay first, then run time
      if (ctl.step && chan_en[ctl.idx]) begin
        if (rd_dly != '0) begin
          dly_ctr[ctl.idx] <= rd_dly - 1'b1;
          if (rd_dly == CTR_W'(1)) begin
            applied[ctl.idx] <= desired[ctl.idx];
          end
        end else if (rd_run != '0) begin
          run_ctr[ctl.idx] <= rd_run - 1'b1;
          if (rd_run == CTR_W'(1)) begin
            desired[ctl.idx] <= ~desired[ctl.idx];
            applied[ctl.idx] <= ~desired[ctl.idx];
          end
        end
      end

      if (ctl.report) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      out_status <= status_q;
      out_levels <= levels;
      out_desired <= id_ok ? desired[id_q[CH_W-1:0]] : 1'b0;
      out_actual <= id_ok ? applied[id_q[CH_W-1:0]] : 1'b0;
      out_run_left <= id_ok ? rd_run : '0;
      out_delay_left <= id_ok ? rd_dly : '0;
    end
  end

endmodule

[rtl/core/trbc_ctrl.sv]
module trbc_ctrl import trbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_REPORT
  } state_t;

  state_t          state;
  logic [CH_W-1:0] idx_q;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

  assign s_tready = (state == S_IDLE);
  assign ctl.load = s_tvalid && s_tready;
  assign ctl.exec = (state == S_EXEC);
  assign ctl.step = (state == S_SWEEP);
  assign ctl.idx = idx_q;
  assign ctl.report = (state == S_REPORT) && !stat.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx_q <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          idx_q <= '0;
          if (stat.cmd == CMD_TICK) begin
            state <= S_SWEEP;
          end else begin
            state <= S_REPORT;
          end
        end
        S_SWEEP: begin
          if (idx_q == LAST_CH) begin
            state <= S_REPORT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_REPORT: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_sweep_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (idx_q <= LAST_CH))
    else $error("sweep index past last channel");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted transaction not executed");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && idx_q == LAST_CH) |=> (state == S_REPORT))
    else $error("sweep did not end in report");

  a_report_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPORT && stat.out_busy) |=> (state == S_REPORT))
    else $error("report left while output busy");

endmodule

[rtl/core/timed_relay_bank_controller_unit.sv]
// Timed relay bank controller: 30 relay channels with delayed apply and timed run.
// Input stream: s_tuser carries the command (tick of 1 ms, set channel, clear all),
// s_tdata the channel id, requested state, run time and delay in seconds.
// Every input transaction yields exactly one output transaction: status in
// m_tuser, driven levels of all channels and the addressed channel's state and
// remaining counts (in ms) in m_tdata, all taken after the command has acted.
// Configuration: cfg_index 0 writes the channel enable mask, 1 the active level.
// cfg_ready is always high; write only while the block is idle.
// Flow: set, clear and unused commands pass from acceptance through S_EXEC and
// S_REPORT to m_tvalid; a tick also sweeps one channel per cycle in S_SWEEP. The next
// input is taken in the cycle after the result is loaded.
// The result sits in an output register; if m_tready is low, one more input is
// taken and worked on, then the block waits until the register frees.
// Reset (rst, synchronous): all channels off, counters cleared, mask 0,
// active level high, output empty.
module timed_relay_bank_controller_unit import trbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,  // relay_id[4:0], state[5], run_time_s[21:6], delay_s[37:22]
  input  logic [CMD_W-1:0]     s_tuser,  // cmd[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [87:0]          m_tdata,  // relay_levels[29:0], chan_desired[30], chan_actual[31],
                                         // run_left_ms[57:32], delay_left_ms[83:58]
  output logic [0:0]           m_tuser,  // status[0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LVL_W-1:0]     cfg_data
);

  dp_cmd_t          ctl;
  dp_stat_t         stat;
  logic             out_status;
  logic [LVL_W-1:0] out_levels;
  logic             out_desired;
  logic             out_actual;
  logic [CTR_W-1:0] out_run_left;
  logic [CTR_W-1:0] out_delay_left;

  assign cfg_ready = 1'b1;

  trbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctl      (ctl)
  );

  trbc_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (s_tuser),
    .in_relay_id    (s_tdata[4:0]),
    .in_state       (s_tdata[5]),
    .in_run_time_s  (s_tdata[21:6]),
    .in_delay_s     (s_tdata[37:22]),
    .ctl            (ctl),
    .stat           (stat),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .out_status     (out_status),
    .out_levels     (out_levels),
    .out_desired    (out_desired),
    .out_actual     (out_actual),
    .out_run_left   (out_run_left),
    .out_delay_left (out_delay_left)
  );

  assign m_tuser = out_status;
  assign m_tdata = {4'b0, out_delay_left, out_run_left, out_actual, out_desired, out_levels};

endmodule
